@@ rtl/assert_macros.svh @@
// assertion macros used by the rtl back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// condition that must hold at every clock edge out of reset
`define PPTF_ASSERT(lbl, clk_s, rst_n_s, cond) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (cond)) \
		else $error("pptf assertion failed");
// consequent that must hold in the cycle after the antecedent
`define PPTF_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("pptf assertion failed");
`else
`define PPTF_ASSERT(lbl, clk_s, rst_n_s, cond)
`define PPTF_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons)
`endif

`endif

@@ rtl/pptf_pkg.sv @@
// shared types, constants and functions of the prompt photon filter
package pptf_pkg;

	localparam int ID_W     = 32;
	localparam int ETA_W    = 12;
	localparam int PT_IN_W  = 16;
	localparam int CNT_W    = 8;
	localparam int BOUND_W  = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int QUEUE_DEPTH = 4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_N_PHOTONS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORDER_PHOTONS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ETA_CUT       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_SUSY    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PTMIN_BY_RANK = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PTMAX_BY_RANK = 3'd5;

	// particle codes
	localparam logic [ID_W:0] PHOTON_ID  = 33'd22;
	localparam logic [ID_W:0] HEAVY_ID   = 33'd100;
	localparam logic [ID_W:0] SUSY_L_LO  = 33'd1000000;
	localparam logic [ID_W:0] SUSY_L_HI  = 33'd1000040;
	localparam logic [ID_W:0] SUSY_R_LO  = 33'd2000000;
	localparam logic [ID_W:0] SUSY_R_HI  = 33'd2000016;

	localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

	typedef struct packed {
		logic [2:0]            n_photons;
		logic                  order_photons;
		logic [10:0]           eta_cut;
		logic                  allow_susy;
		logic [CFG_DATA_W-1:0] ptmin_by_rank;
		logic [CFG_DATA_W-1:0] ptmax_by_rank;
	} pptf_cfg_t;

	localparam pptf_cfg_t CFG_RESET = '{
		n_photons:     3'd1,
		order_photons: 1'b1,
		eta_cut:       11'd640,
		allow_susy:    1'b0,
		ptmin_by_rank: 64'h0064_0064_0064_0064,
		ptmax_by_rank: 64'hFFFF_FFFF_FFFF_FFFF
	};

	// classification of one closed particle, front to back
	typedef struct packed {
		logic prompt;
		logic in_win;
		logic last_evt;
	} pptf_flags_t;

	// window bound of a rank; ranks past the fourth reuse the fourth
	function automatic logic [BOUND_W-1:0] pptf_bound(logic [CFG_DATA_W-1:0] wv,
		int unsigned rank);
		logic [BOUND_W-1:0] b;
		if (rank >= 3) begin
			b = wv[63:48];
		end else if (rank == 2) begin
			b = wv[47:32];
		end else if (rank == 1) begin
			b = wv[31:16];
		end else begin
			b = wv[15:0];
		end
		return b;
	endfunction

endpackage

@@ rtl/pptf_ifs.sv @@
// channel interfaces: particle items, verdict results, configuration writes
interface pptf_item_if;
	logic                                valid;
	logic                                ready;
	logic signed [pptf_pkg::ID_W-1:0]    particle_id;
	logic                                is_stable;
	logic signed [pptf_pkg::ETA_W-1:0]   eta;
	logic [pptf_pkg::PT_IN_W-1:0]        pt;
	logic                                has_parent;
	logic signed [pptf_pkg::ID_W-1:0]    parent_id;
	logic                                last_parent;
	logic                                last_in_event;

	modport source (output valid, particle_id, is_stable, eta, pt, has_parent, parent_id,
		last_parent, last_in_event, input ready);
	modport sink (input valid, particle_id, is_stable, eta, pt, has_parent, parent_id,
		last_parent, last_in_event, output ready);
endinterface

interface pptf_result_if;
	logic                          valid;
	logic                          ready;
	logic                          passed;
	logic [pptf_pkg::CNT_W-1:0]    prompt_count;
	logic [pptf_pkg::CNT_W-1:0]    window_count;

	modport source (output valid, passed, prompt_count, window_count, input ready);
	modport sink (input valid, passed, prompt_count, window_count, output ready);
endinterface

interface pptf_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [pptf_pkg::CFG_IDX_W-1:0]    index;
	logic [pptf_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/pptf_queue.sv @@
// short fifo between the classifying front and the sorting back
module pptf_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             not_empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign dout      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

@@ rtl/pptf_front.sv @@
// front: takes item transfers, tracks the hadron mark, classifies closed particles
module pptf_front #(
	parameter int PT_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	pptf_item_if.sink            item,
	input  pptf_pkg::pptf_cfg_t  cfg,
	input  logic                 q_full,
	output logic                 q_push,
	output pptf_pkg::pptf_flags_t q_flags,
	output logic [PT_BITS-1:0]   q_pt
);
	localparam int CW = (PT_BITS > pptf_pkg::PT_IN_W) ? PT_BITS : pptf_pkg::PT_IN_W;
	localparam logic [CW:0] SAT_W = ({{CW{1'b0}}, 1'b1} << PT_BITS) - 1'b1;
	localparam logic [CW-1:0] SAT_MAX = SAT_W[CW-1:0];

	logic                          mark_q;
	logic                          accept, closing, mark_now, heavy, susy, prompt;
	logic [pptf_pkg::ID_W:0]       par_ext, par_abs, pid_ext;
	logic [pptf_pkg::ETA_W:0]      eta_ext, eta_abs;
	logic [CW-1:0]                 pt_ext, pt_sat;

	assign item.ready = !q_full;
	assign accept     = item.valid && item.ready;
	assign closing    = item.last_parent || item.last_in_event;

	// parent magnitude, 33 bits so the most negative code stays positive
	assign par_ext = {item.parent_id[pptf_pkg::ID_W-1], item.parent_id};
	assign par_abs = item.parent_id[pptf_pkg::ID_W-1] ? (~par_ext + 1'b1) : par_ext;
	assign heavy   = par_abs > pptf_pkg::HEAVY_ID;
	assign susy    = (par_abs > pptf_pkg::SUSY_L_LO && par_abs < pptf_pkg::SUSY_L_HI) ||
		(par_abs > pptf_pkg::SUSY_R_LO && par_abs < pptf_pkg::SUSY_R_HI);

	always_comb begin
		mark_now = mark_q;
		if (item.has_parent && heavy) begin
			mark_now = !(cfg.allow_susy && susy);
		end
	end

	assign pid_ext = {item.particle_id[pptf_pkg::ID_W-1], item.particle_id};
	assign eta_ext = {item.eta[pptf_pkg::ETA_W-1], item.eta};
	assign eta_abs = item.eta[pptf_pkg::ETA_W-1] ? (~eta_ext + 1'b1) : eta_ext;

	assign pt_ext = CW'(item.pt);
	assign pt_sat = (pt_ext > SAT_MAX) ? SAT_MAX : pt_ext;

	assign prompt = (pid_ext == pptf_pkg::PHOTON_ID) && item.is_stable &&
		(eta_abs <= {2'b00, cfg.eta_cut}) && !mark_now;

	assign q_flags.prompt   = prompt;
	assign q_flags.in_win   = (pt_sat > CW'(pptf_pkg::pptf_bound(cfg.ptmin_by_rank, 0))) &&
		(pt_sat < CW'(pptf_pkg::pptf_bound(cfg.ptmax_by_rank, 0)));
	assign q_flags.last_evt = item.last_in_event;
	assign q_pt             = pt_sat[PT_BITS-1:0];

	// only closed photons and event ends matter downstream
	assign q_push = accept && closing && (prompt || item.last_in_event);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= 1'b0;
		end else if (accept) begin
			mark_q <= closing ? 1'b0 : mark_now;
		end
	end
endmodule

@@ rtl/pptf_back.sv @@
// back: top-n pt sorter, saturating counters and the event verdict register
`include "assert_macros.svh"

module pptf_back #(
	parameter int MAX_RANKS = 4,
	parameter int PT_BITS   = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pptf_pkg::pptf_cfg_t   cfg,
	input  logic                  q_not_empty,
	input  pptf_pkg::pptf_flags_t q_flags,
	input  logic [PT_BITS-1:0]    q_pt,
	output logic                  q_pop,
	pptf_result_if.source         result
);
	localparam int CW = (PT_BITS > pptf_pkg::BOUND_W) ? PT_BITS : pptf_pkg::BOUND_W;

	logic [PT_BITS-1:0]          top_pt_q [MAX_RANKS];
	logic [MAX_RANKS-1:0]        top_valid_q;
	logic [pptf_pkg::CNT_W-1:0]  prompt_q, win_q;
	logic                        res_valid_q, passed_q;
	logic [pptf_pkg::CNT_W-1:0]  res_prompt_q, res_win_q;

	logic [PT_BITS-1:0]          sh_pt [MAX_RANKS];
	logic [MAX_RANKS-1:0]        sh_valid;
	logic [PT_BITS-1:0]          nxt_pt [MAX_RANKS];
	logic [MAX_RANKS-1:0]        nxt_valid, ge, prev_ge, rank_fail;
	logic [pptf_pkg::CNT_W-1:0]  prompt_nxt, win_nxt;
	logic                        verdict;

	// an event end waits for the result register to free up
	assign q_pop = q_not_empty && (!q_flags.last_evt || !res_valid_q || result.ready);

	// parallel insert: ranks holding pt >= new stay, the first other rank takes it,
	// ranks below shift down by one
	always_comb begin
		sh_pt[0]    = q_pt;
		sh_valid[0] = 1'b1;
		for (int i = 1; i < MAX_RANKS; i++) begin
			sh_pt[i]    = top_pt_q[i-1];
			sh_valid[i] = top_valid_q[i-1];
		end
		for (int i = 0; i < MAX_RANKS; i++) begin
			ge[i] = top_valid_q[i] && (top_pt_q[i] >= q_pt);
		end
		prev_ge = (ge << 1) | MAX_RANKS'(1);
		for (int i = 0; i < MAX_RANKS; i++) begin
			if (!q_flags.prompt || ge[i]) begin
				nxt_pt[i]    = top_pt_q[i];
				nxt_valid[i] = top_valid_q[i];
			end else if (prev_ge[i]) begin
				nxt_pt[i]    = q_pt;
				nxt_valid[i] = 1'b1;
			end else begin
				nxt_pt[i]    = sh_pt[i];
				nxt_valid[i] = sh_valid[i];
			end
		end
	end

	assign prompt_nxt = (q_flags.prompt && prompt_q != pptf_pkg::CNT_MAX) ?
		prompt_q + 1'b1 : prompt_q;
	assign win_nxt = (q_flags.prompt && q_flags.in_win && win_q != pptf_pkg::CNT_MAX) ?
		win_q + 1'b1 : win_q;

	// per-rank inclusive windows on the sorted state after this photon
	always_comb begin
		for (int i = 0; i < MAX_RANKS; i++) begin
			rank_fail[i] = (i < int'(cfg.n_photons)) && (!nxt_valid[i] ||
				(CW'(nxt_pt[i]) < CW'(pptf_pkg::pptf_bound(cfg.ptmin_by_rank, i))) ||
				(CW'(nxt_pt[i]) > CW'(pptf_pkg::pptf_bound(cfg.ptmax_by_rank, i))));
		end
		if (cfg.order_photons) begin
			verdict = (prompt_nxt >= pptf_pkg::CNT_W'(cfg.n_photons)) && (rank_fail == '0);
		end else begin
			verdict = win_nxt >= pptf_pkg::CNT_W'(cfg.n_photons);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_valid_q <= '0;
			prompt_q    <= '0;
			win_q       <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < MAX_RANKS; i++) begin
				top_pt_q[i] <= '0;
			end
		end else begin
			if (q_pop) begin
				if (q_flags.last_evt) begin
					top_valid_q <= '0;
					prompt_q    <= '0;
					win_q       <= '0;
					for (int i = 0; i < MAX_RANKS; i++) begin
						top_pt_q[i] <= '0;
					end
				end else begin
					top_valid_q <= nxt_valid;
					prompt_q    <= prompt_nxt;
					win_q       <= win_nxt;
					for (int i = 0; i < MAX_RANKS; i++) begin
						top_pt_q[i] <= nxt_pt[i];
					end
				end
			end
			if (q_pop && q_flags.last_evt) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_flags.last_evt) begin
			passed_q     <= verdict;
			res_prompt_q <= prompt_nxt;
			res_win_q    <= win_nxt;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.passed       = passed_q;
	assign result.prompt_count = res_prompt_q;
	assign result.window_count = res_win_q;

	// kept ranks always fill from rank zero without holes
	`PPTF_ASSERT(a_valid_prefix, clk, arst_n, (top_valid_q & ~((top_valid_q << 1) | MAX_RANKS'(1))) == '0)
	// a window photon is always a prompt photon
	`PPTF_ASSERT(a_win_le_prompt, clk, arst_n, win_q <= prompt_q)
	// an event end leaves a result and clean event state
	`PPTF_ASSERT_NEXT(a_event_clear, clk, arst_n, q_pop && q_flags.last_evt, res_valid_q && prompt_q == '0 && top_valid_q == '0)
endmodule

@@ rtl/prompt_photon_topn_filter_core.sv @@
// top level of the prompt photon top-n filter
//
//   channel   dir   transfer moves
//   item      in    one (particle, parent) record
//   result    out   one event verdict with prompt and window counts
//   cfg       in    one register write, index and 64-bit data
//
// one item transfer per cycle while the queue has room; the limit is the
// parallel insert of the back sorter, draining one entry per cycle unless stalled
// result registered once the event's last item has passed through the queue
// arst_n clears the event state, the queue and the configuration to defaults
// a stalled result blocks the queue once an event end reaches its head
// item ready drops only when the four-entry queue is full
module prompt_photon_topn_filter_core #(
	parameter int MAX_RANKS = 4,
	parameter int PT_BITS   = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	pptf_item_if.sink     item,
	pptf_result_if.source result,
	pptf_cfg_if.sink      cfg
);
	localparam int QW = $bits(pptf_pkg::pptf_flags_t) + PT_BITS;

	pptf_pkg::pptf_cfg_t   cfg_q;
	pptf_pkg::pptf_flags_t f_flags, b_flags;
	logic [PT_BITS-1:0]    f_pt, b_pt;
	logic                  q_push, q_pop, q_full, q_not_empty;
	logic [QW-1:0]         q_din, q_dout;

	// configuration registers, writes always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= pptf_pkg::CFG_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				pptf_pkg::CFG_N_PHOTONS:     cfg_q.n_photons     <= cfg.data[2:0];
				pptf_pkg::CFG_ORDER_PHOTONS: cfg_q.order_photons <= cfg.data[0];
				pptf_pkg::CFG_ETA_CUT:       cfg_q.eta_cut       <= cfg.data[10:0];
				pptf_pkg::CFG_ALLOW_SUSY:    cfg_q.allow_susy    <= cfg.data[0];
				pptf_pkg::CFG_PTMIN_BY_RANK: cfg_q.ptmin_by_rank <= cfg.data;
				pptf_pkg::CFG_PTMAX_BY_RANK: cfg_q.ptmax_by_rank <= cfg.data;
				default: begin
					// writes past the register list are dropped
				end
			endcase
		end
	end

	// front classifies each closed particle
	pptf_front #(
		.PT_BITS(PT_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.cfg     (cfg_q),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_flags (f_flags),
		.q_pt    (f_pt)
	);

	assign q_din = {f_flags, f_pt};

	// decoupling queue
	pptf_queue #(
		.WIDTH(QW),
		.DEPTH(pptf_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.din       (q_din),
		.full      (q_full),
		.pop       (q_pop),
		.dout      (q_dout),
		.not_empty (q_not_empty)
	);

	assign b_flags = q_dout[QW-1:PT_BITS];
	assign b_pt    = q_dout[PT_BITS-1:0];

	// back sorts, counts and issues the verdict
	pptf_back #(
		.MAX_RANKS(MAX_RANKS),
		.PT_BITS  (PT_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_not_empty (q_not_empty),
		.q_flags     (b_flags),
		.q_pt        (b_pt),
		.q_pop       (q_pop),
		.result      (result)
	);
endmodule

@@ sim/tb_prompt_photon_topn_filter_core.sv @@
// testbench of the prompt photon top-n filter: directed and random events checked against a verdict predictor
module tb_prompt_photon_topn_filter_core;

	localparam int RANKS            = 4;
	localparam int LIMIT_CYCLES     = 300000;
	localparam int DRAIN_CYCLES     = 16;
	localparam int LONG_HOLD_CYCLES = 200;
	localparam int PHOTON           = int'(pptf_pkg::PHOTON_ID);
	// index with no register behind it, writes there are dropped
	localparam logic [pptf_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd6;

	// one (particle, parent) record as it crosses the item channel
	typedef struct {
		logic signed [pptf_pkg::ID_W-1:0]  particle_id;
		logic                              is_stable;
		logic signed [pptf_pkg::ETA_W-1:0] eta;
		logic [pptf_pkg::PT_IN_W-1:0]      pt;
		logic                              has_parent;
		logic signed [pptf_pkg::ID_W-1:0]  parent_id;
		logic                              last_parent;
		logic                              last_in_event;
	} particle_item_t;

	typedef struct {
		logic                       passed;
		logic [pptf_pkg::CNT_W-1:0] prompt_count;
		logic [pptf_pkg::CNT_W-1:0] window_count;
	} verdict_t;

	logic clk;
	logic arst_n;

	pptf_item_if   item_ch();
	pptf_result_if result_ch();
	pptf_cfg_if    cfg_ch();

	prompt_photon_topn_filter_core #(
		.MAX_RANKS(RANKS),
		.PT_BITS  (pptf_pkg::PT_IN_W)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.result(result_ch),
		.cfg   (cfg_ch)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// records waiting for the driver, verdicts waiting for the block
	particle_item_t pending_items[$];
	verdict_t       expected_verdicts[$];

	// register copy, updated on each cfg transfer
	logic [2:0]                      cfg_n       = pptf_pkg::CFG_RESET.n_photons;
	logic                            cfg_ordered = pptf_pkg::CFG_RESET.order_photons;
	logic [10:0]                     cfg_eta_cut = pptf_pkg::CFG_RESET.eta_cut;
	logic                            cfg_susy    = pptf_pkg::CFG_RESET.allow_susy;
	logic [pptf_pkg::CFG_DATA_W-1:0] cfg_ptmin   = pptf_pkg::CFG_RESET.ptmin_by_rank;
	logic [pptf_pkg::CFG_DATA_W-1:0] cfg_ptmax   = pptf_pkg::CFG_RESET.ptmax_by_rank;

	// event state of the predictor
	logic [pptf_pkg::PT_IN_W-1:0] ev_top_pt[RANKS];
	logic                         ev_top_valid[RANKS];
	logic                         ev_hadron;
	logic [pptf_pkg::CNT_W-1:0]   ev_prompt;
	logic [pptf_pkg::CNT_W-1:0]   ev_window;

	int   errors = 0;
	int   cycle_count = 0;
	logic item_taken;

	// traffic shaping, owned by the stimulus process
	logic steady;
	logic long_hold_req;

	// sender burst state
	int burst_left = 0;
	int gap_left = 0;

	// receiver stall state
	int   rx_tick = 0;
	int   rx_mode = 0;
	int   rx_hold_left = 0;
	logic rx_hold_done = 1'b0;

	// window bound of a rank; ranks past the fourth share the fourth window
	function automatic logic [pptf_pkg::BOUND_W-1:0] rank_bound(
		logic [pptf_pkg::CFG_DATA_W-1:0] w, int rank);
		int r;
		r = (rank > 3) ? 3 : rank;
		return w[16*r +: 16];
	endfunction

	task automatic clear_event_state();
		for (int i = 0; i < RANKS; i++) begin
			ev_top_pt[i] = '0;
			ev_top_valid[i] = 1'b0;
		end
		ev_hadron = 1'b0;
		ev_prompt = '0;
		ev_window = '0;
	endtask

	initial clear_event_state();

	// advances the event state by one record, queues a verdict on event end
	task automatic predict_verdict(input particle_item_t it);
		longint   par_mag;
		longint   eta_mag;
		logic     susy_id;
		logic     pass;
		int       pos;
		verdict_t v;
		// the latest heavy parent decides the mark; light parents leave it alone
		if (it.has_parent) begin
			par_mag = it.parent_id;
			if (par_mag < 0) par_mag = -par_mag;
			if (par_mag > longint'(pptf_pkg::HEAVY_ID)) begin
				susy_id = (par_mag > longint'(pptf_pkg::SUSY_L_LO) &&
					par_mag < longint'(pptf_pkg::SUSY_L_HI)) ||
					(par_mag > longint'(pptf_pkg::SUSY_R_LO) &&
					par_mag < longint'(pptf_pkg::SUSY_R_HI));
				ev_hadron = !(cfg_susy && susy_id);
			end
		end
		// closing record, or event end in the middle of a particle
		if (it.last_parent || it.last_in_event) begin
			eta_mag = it.eta;
			if (eta_mag < 0) eta_mag = -eta_mag;
			if (it.particle_id == PHOTON && it.is_stable && eta_mag <= longint'(cfg_eta_cut) &&
				!ev_hadron) begin
				if (ev_prompt != pptf_pkg::CNT_MAX) ev_prompt++;
				if (it.pt > rank_bound(cfg_ptmin, 0) && it.pt < rank_bound(cfg_ptmax, 0) &&
					ev_window != pptf_pkg::CNT_MAX)
					ev_window++;
				// descending order, a tie lands below the kept equal values
				pos = 0;
				while (pos < RANKS && ev_top_valid[pos] && ev_top_pt[pos] >= it.pt) pos++;
				if (pos < RANKS) begin
					for (int i = RANKS - 1; i > pos; i--) begin
						ev_top_pt[i] = ev_top_pt[i-1];
						ev_top_valid[i] = ev_top_valid[i-1];
					end
					ev_top_pt[pos] = it.pt;
					ev_top_valid[pos] = 1'b1;
				end
			end
			ev_hadron = 1'b0;
		end
		if (it.last_in_event) begin
			if (cfg_ordered) begin
				// inclusive window per rank, only the kept ranks are looked at
				pass = (ev_prompt >= pptf_pkg::CNT_W'(cfg_n));
				for (int i = 0; i < int'(cfg_n) && i < RANKS; i++) begin
					if (!ev_top_valid[i] || ev_top_pt[i] < rank_bound(cfg_ptmin, i) ||
						ev_top_pt[i] > rank_bound(cfg_ptmax, i))
						pass = 1'b0;
				end
			end else begin
				pass = (ev_window >= pptf_pkg::CNT_W'(cfg_n));
			end
			v.passed = pass;
			v.prompt_count = ev_prompt;
			v.window_count = ev_window;
			expected_verdicts.insert(expected_verdicts.size(), v);
			clear_event_state();
		end
	endtask

	// ---------------------------------------------------------------- random fields

	function automatic logic signed [pptf_pkg::ID_W-1:0] rand_particle_id();
		int others[4] = '{11, 21, 23, 0};
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return -PHOTON;
			2: return others[$urandom_range(0, 3)];
			3: return PHOTON ^ (32'sd1 << $urandom_range(0, 31));
			4: return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			default: return PHOTON;
		endcase
	endfunction

	function automatic logic signed [pptf_pkg::ID_W-1:0] rand_parent_id();
		int hadrons[5] = '{111, 211, 2212, 101, 321};
		// magnitudes right at and just past the edges of the susy ranges
		int edges[8] = '{1000000, 1000001, 1000039, 1000040, 2000000, 2000001, 2000015,
			2000016};
		int mag;
		case ($urandom_range(0, 9))
			0: mag = $urandom_range(0, 100);
			1, 2: mag = hadrons[$urandom_range(0, 4)];
			3, 4: mag = $urandom_range(0, 1) ? $urandom_range(1000001, 1000039) :
				$urandom_range(2000001, 2000015);
			5: mag = edges[$urandom_range(0, 7)];
			6: return $urandom;
			7: return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			default: mag = $urandom_range(101, 3000000);
		endcase
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	// pt values cluster on the window bounds of the current setting
	function automatic logic [pptf_pkg::PT_IN_W-1:0] rand_pt();
		int v;
		int r;
		r = $urandom_range(0, 3);
		case ($urandom_range(0, 7))
			0: v = $urandom_range(0, 65535);
			1: v = int'(rank_bound(cfg_ptmin, r)) + int'($urandom_range(0, 2)) - 1;
			2: v = int'(rank_bound(cfg_ptmax, r)) + int'($urandom_range(0, 2)) - 1;
			3: v = $urandom_range(0, 1) ? 65535 : 0;
			default: v = $urandom_range(rank_bound(cfg_ptmin, r), rank_bound(cfg_ptmax, r));
		endcase
		if (v < 0) v = 0;
		if (v > 65535) v = 65535;
		return pptf_pkg::PT_IN_W'(v);
	endfunction

	function automatic logic signed [pptf_pkg::ETA_W-1:0] rand_eta();
		int v;
		int c;
		c = int'(cfg_eta_cut);
		case ($urandom_range(0, 5))
			0: v = int'($urandom_range(0, 4095)) - 2048;
			1: v = (c + int'($urandom_range(0, 4)) - 2) * ($urandom_range(0, 1) ? 1 : -1);
			2: v = -2048;
			default: v = int'($urandom_range(0, 2 * c)) - c;
		endcase
		if (v < -2048) v = -2048;
		if (v > 2047) v = 2047;
		return pptf_pkg::ETA_W'(v);
	endfunction

	// one event: particles with one to three parent records each
	task automatic queue_random_event(output int n_items);
		particle_item_t base;
		particle_item_t it;
		int n_part;
		int n_par;
		int n_rec;
		int stop_at;
		n_items = 0;
		n_part = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
		for (int p = 0; p < n_part; p++) begin
			base.particle_id = rand_particle_id();
			base.is_stable = ($urandom_range(0, 6) != 0);
			base.eta = rand_eta();
			base.pt = rand_pt();
			n_par = $urandom_range(0, 3);
			n_rec = (n_par == 0) ? 1 : n_par;
			// now and then the event ends before its last particle is closed
			stop_at = -1;
			if (p == n_part - 1 && n_par > 1 && $urandom_range(0, 5) == 0)
				stop_at = $urandom_range(0, n_par - 2);
			for (int k = 0; k < n_rec; k++) begin
				it = base;
				it.has_parent = (k < n_par) && ($urandom_range(0, 9) != 0);
				it.parent_id = it.has_parent ? rand_parent_id() : $urandom;
				// particle fields only count on the closing record
				if (k < n_rec - 1 && $urandom_range(0, 3) == 0) begin
					it.particle_id = $urandom;
					it.is_stable = ($urandom_range(0, 1) != 0);
					it.eta = pptf_pkg::ETA_W'($urandom);
					it.pt = pptf_pkg::PT_IN_W'($urandom);
				end
				it.last_parent = (k == n_rec - 1);
				it.last_in_event = (p == n_part - 1 && k == n_rec - 1) || (k == stop_at);
				pending_items.insert(pending_items.size(), it);
				n_items++;
				if (k == stop_at) break;
			end
		end
	endtask

	// ---------------------------------------------------------------- stimulus helpers

	task automatic put(input logic signed [pptf_pkg::ID_W-1:0] pid, input logic stable,
		input logic signed [pptf_pkg::ETA_W-1:0] eta, input logic [pptf_pkg::PT_IN_W-1:0] pt,
		input logic has_par, input logic signed [pptf_pkg::ID_W-1:0] par_id,
		input logic last_par, input logic last_evt);
		particle_item_t it;
		it.particle_id = pid;
		it.is_stable = stable;
		it.eta = eta;
		it.pt = pt;
		it.has_parent = has_par;
		it.parent_id = par_id;
		it.last_parent = last_par;
		it.last_in_event = last_evt;
		pending_items.insert(pending_items.size(), it);
	endtask

	// returns once the sender is empty, every verdict is in and the block has settled
	task automatic wait_idle();
		while (pending_items.size() != 0 || item_ch.valid || expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [pptf_pkg::CFG_IDX_W-1:0] idx,
		input logic [pptf_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			pptf_pkg::CFG_N_PHOTONS:     cfg_n = data[2:0];
			pptf_pkg::CFG_ORDER_PHOTONS: cfg_ordered = data[0];
			pptf_pkg::CFG_ETA_CUT:       cfg_eta_cut = data[10:0];
			pptf_pkg::CFG_ALLOW_SUSY:    cfg_susy = data[0];
			pptf_pkg::CFG_PTMIN_BY_RANK: cfg_ptmin = data;
			pptf_pkg::CFG_PTMAX_BY_RANK: cfg_ptmax = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// narrow fields go out with random upper bits, which the block drops
	task automatic apply_config(input int n, input logic ordered, input int cut,
		input logic susy, input logic [pptf_pkg::CFG_DATA_W-1:0] mins,
		input logic [pptf_pkg::CFG_DATA_W-1:0] maxs);
		logic [pptf_pkg::CFG_DATA_W-1:0] d;
		d = {$urandom, $urandom};
		d[2:0] = 3'(n);
		cfg_write(pptf_pkg::CFG_N_PHOTONS, d);
		d = {$urandom, $urandom};
		d[0] = ordered;
		cfg_write(pptf_pkg::CFG_ORDER_PHOTONS, d);
		d = {$urandom, $urandom};
		d[10:0] = 11'(cut);
		cfg_write(pptf_pkg::CFG_ETA_CUT, d);
		d = {$urandom, $urandom};
		d[0] = susy;
		cfg_write(pptf_pkg::CFG_ALLOW_SUSY, d);
		cfg_write(pptf_pkg::CFG_PTMIN_BY_RANK, mins);
		cfg_write(pptf_pkg::CFG_PTMAX_BY_RANK, maxs);
	endtask

	task automatic random_windows(output logic [pptf_pkg::CFG_DATA_W-1:0] mins,
		output logic [pptf_pkg::CFG_DATA_W-1:0] maxs);
		int lo;
		if ($urandom_range(0, 4) == 0) begin
			mins = {$urandom, $urandom};
			maxs = {$urandom, $urandom};
		end else begin
			for (int r = 0; r < RANKS; r++) begin
				lo = $urandom_range(0, 3000);
				mins[16*r +: 16] = 16'(lo);
				maxs[16*r +: 16] = 16'(lo + int'($urandom_range(0, 40000)));
			end
		end
	endtask

	task automatic run_random(input int target);
		int got;
		int k;
		got = 0;
		while (got < target) begin
			queue_random_event(k);
			got += k;
		end
		wait_idle();
	endtask

	// ---------------------------------------------------------------- driver

	// offers records in bursts with gaps, holds each until its transfer
	always @(negedge clk) begin : item_driver
		logic offer;
		particle_item_t it;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else if (!(item_ch.valid && !item_taken)) begin
			offer = 1'b0;
			if (gap_left != 0 && !steady) begin
				gap_left--;
			end else if (pending_items.size() != 0) begin
				it = pending_items.pop_front();
				item_ch.particle_id <= it.particle_id;
				item_ch.is_stable <= it.is_stable;
				item_ch.eta <= it.eta;
				item_ch.pt <= it.pt;
				item_ch.has_parent <= it.has_parent;
				item_ch.parent_id <= it.parent_id;
				item_ch.last_parent <= it.last_parent;
				item_ch.last_in_event <= it.last_in_event;
				offer = 1'b1;
				if (burst_left != 0) burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 16);
					gap_left = $urandom_range(0, 1) ? $urandom_range(1, 8) : 0;
				end
			end
			item_ch.valid <= offer;
		end
	end

	// ---------------------------------------------------------------- receiver

	// stall pattern is redrawn whenever rx_tick wraps; one long hold-off on request
	always @(negedge clk) begin : verdict_receiver
		logic rdy;
		if (rx_hold_left != 0) begin
			rdy = 1'b0;
			rx_hold_left--;
			if (rx_hold_left == 0) rx_hold_done = 1'b1;
		end else if (long_hold_req && !rx_hold_done) begin
			rdy = 1'b0;
			rx_hold_left = LONG_HOLD_CYCLES;
		end else if (steady) begin
			rdy = 1'b1;
		end else begin
			if (rx_tick == 0) rx_mode = $urandom_range(0, 3);
			rx_tick = (rx_tick + 1) % 64;
			case (rx_mode)
				0: rdy = 1'b1;
				1: rdy = ($urandom_range(0, 1) != 0);
				2: rdy = (rx_tick % 4) == 0;
				default: rdy = ($urandom_range(0, 9) != 0);
			endcase
		end
		result_ch.ready <= rdy;
	end

	// ---------------------------------------------------------------- monitor

	// checks each verdict transfer, then feeds the record transfer to the predictor
	always @(posedge clk) begin : transfer_monitor
		particle_item_t seen;
		verdict_t want;
		if (!arst_n) begin
			item_taken <= 1'b0;
		end else begin
			item_taken <= item_ch.valid && item_ch.ready;
			if (result_ch.valid && result_ch.ready) begin
				if (expected_verdicts.size() == 0) begin
					$error("verdict transfer with none pending: passed %0d prompt %0d window %0d",
						result_ch.passed, result_ch.prompt_count, result_ch.window_count);
					errors++;
				end else begin
					want = expected_verdicts.pop_front();
					if (result_ch.passed !== want.passed) begin
						$error("passed: expected %0d, actual %0d", want.passed, result_ch.passed);
						errors++;
					end
					if (result_ch.prompt_count !== want.prompt_count) begin
						$error("prompt_count: expected %0d, actual %0d", want.prompt_count,
							result_ch.prompt_count);
						errors++;
					end
					if (result_ch.window_count !== want.window_count) begin
						$error("window_count: expected %0d, actual %0d", want.window_count,
							result_ch.window_count);
						errors++;
					end
				end
			end
			if (item_ch.valid && item_ch.ready) begin
				seen.particle_id = item_ch.particle_id;
				seen.is_stable = item_ch.is_stable;
				seen.eta = item_ch.eta;
				seen.pt = item_ch.pt;
				seen.has_parent = item_ch.has_parent;
				seen.parent_id = item_ch.parent_id;
				seen.last_parent = item_ch.last_parent;
				seen.last_in_event = item_ch.last_in_event;
				predict_verdict(seen);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- stimulus

	initial begin : stimulus
		logic [pptf_pkg::CFG_DATA_W-1:0] mins;
		logic [pptf_pkg::CFG_DATA_W-1:0] maxs;
		arst_n = 1'b0;
		steady = 1'b0;
		long_hold_req = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.particle_id = '0;
		item_ch.is_stable = 1'b0;
		item_ch.eta = '0;
		item_ch.pt = '0;
		item_ch.has_parent = 1'b0;
		item_ch.parent_id = '0;
		item_ch.last_parent = 1'b0;
		item_ch.last_in_event = 1'b0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed events under the reset setting
		// lone prompt photon
		put(PHOTON, 1, 0, 500, 0, 0, 1, 1);
		// saturated pt at the eta edge: fails the strict rank-0 upper bound only
		put(PHOTON, 1, 640, 16'hFFFF, 0, 0, 1, 1);
		// eta of -2048 and just past the cut, then exactly on the cut with pt on ptmin
		put(PHOTON, 1, -2048, 500, 0, 0, 1, 0);
		put(PHOTON, 1, -641, 500, 0, 0, 1, 0);
		put(PHOTON, 1, -640, 100, 0, 0, 1, 1);
		// a light parent after a hadron keeps the mark
		put(PHOTON, 1, 10, 800, 1, 211, 0, 0);
		put(PHOTON, 1, 10, 800, 1, 21, 1, 0);
		// susy parent is hadronic while not allowed
		put(PHOTON, 1, 10, 800, 1, -2212, 0, 0);
		put(PHOTON, 1, 10, 800, 1, 1000022, 1, 0);
		// most negative parent id counts as heavy
		put(PHOTON, 1, 10, 800, 1, 32'sh8000_0000, 1, 0);
		// only the closing record's particle fields count
		put(11, 0, -2000, 7, 1, 21, 0, 0);
		put(PHOTON, 1, 3, 1200, 1, -5, 1, 1);
		// sorter ties and more photons than ranks
		put(PHOTON, 1, 0, 300, 0, 0, 1, 0);
		put(PHOTON, 1, 0, 300, 0, 0, 1, 0);
		put(PHOTON, 1, 0, 700, 0, 0, 1, 0);
		put(PHOTON, 1, 0, 300, 0, 0, 1, 0);
		put(PHOTON, 1, 0, 50, 0, 0, 1, 0);
		put(PHOTON, 1, 0, 900, 0, 0, 1, 1);
		// event end in the middle of a particle closes it
		put(PHOTON, 1, 0, 400, 1, 2212, 0, 1);
		put(PHOTON, 1, 0, 400, 1, 3, 0, 1);
		// extreme ids and non-stable photon
		put(32'sh8000_0000, 1, 2047, 0, 1, 32'sh7FFF_FFFF, 1, 0);
		put(PHOTON, 0, 0, 900, 0, 0, 1, 0);
		put(32'sh7FFF_FFFF, 1, 0, 0, 1, 101, 1, 1);
		wait_idle();

		// no photon required, every window open; 260 photons saturate both counts
		apply_config(0, 1, 2047, 1, 64'h0, '1);
		cfg_write(CFG_UNUSED_IDX, {$urandom, $urandom});
		for (int k = 0; k < 260; k++)
			put(PHOTON, 1, pptf_pkg::ETA_W'($urandom_range(0, 255)),
				pptf_pkg::PT_IN_W'($urandom_range(1, 65534)), 0, $urandom, 1, k == 259);
		run_random(80);

		// eta cut of zero, count mode
		apply_config(1, 0, 0, 1, 64'h0064_0064_0064_0064, '1);
		run_random(80);

		// more photons asked than ranks kept
		apply_config(7, 1, 2047, 1, 64'h0, '1);
		run_random(80);
		apply_config(7, 0, 2047, 0, 64'h0, '1);
		run_random(80);

		// windows that nothing fits in
		apply_config(2, 0, 1023, 1, '1, 64'h0);
		run_random(80);

		random_windows(mins, maxs);
		apply_config(4, 1, 2047, 0, mins, maxs);
		run_random(80);

		// a stretch with no idling on either side
		random_windows(mins, maxs);
		apply_config($urandom_range(1, 4), 1'($urandom_range(0, 1)), $urandom_range(300, 2047),
			1'($urandom_range(0, 1)), mins, maxs);
		steady = 1'b1;
		run_random(80);
		steady = 1'b0;

		// receiver holds off while short events pile up in the block
		apply_config(1, 0, 2047, 0, 64'h0, '1);
		steady = 1'b1;
		long_hold_req = 1'b1;
		for (int k = 0; k < 40; k++)
			put(PHOTON, 1, rand_eta(), rand_pt(), 1'($urandom_range(0, 1)), rand_parent_id(),
				1, 1);
		wait_idle();
		long_hold_req = 1'b0;
		steady = 1'b0;

		for (int ph = 0; ph < 4; ph++) begin
			random_windows(mins, maxs);
			apply_config($urandom_range(0, 7), 1'($urandom_range(0, 1)),
				$urandom_range(0, 2047), 1'($urandom_range(0, 1)), mins, maxs);
			run_random(80);
		end

		wait_idle();
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/pptf_pkg.sv
rtl/pptf_ifs.sv
rtl/pptf_queue.sv
rtl/pptf_front.sv
rtl/pptf_back.sv
rtl/prompt_photon_topn_filter_core.sv
sim/tb_prompt_photon_topn_filter_core.sv
